### design/clb_pkg.sv
package clb_pkg;

  localparam int IDX_W = 64;
  localparam int TERM_W = 64;
  localparam int FUNC_W = 3;
  localparam int STAT_W = 3;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_APPEND    = 3'd0;
  localparam logic [FUNC_W-1:0] FN_STABLE_TO = 3'd1;
  localparam logic [FUNC_W-1:0] FN_RESTORE   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_LOOKUP    = 3'd3;
  localparam logic [FUNC_W-1:0] FN_LAST_IDX  = 3'd4;
  localparam logic [FUNC_W-1:0] FN_SLICE     = 3'd5;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK           = 3'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND    = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL         = 3'd2;
  localparam logic [STAT_W-1:0] ST_GAP          = 3'd3;
  localparam logic [STAT_W-1:0] ST_BAD_RANGE    = 3'd4;
  localparam logic [STAT_W-1:0] ST_OUT_OF_BOUND = 3'd5;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0]  entry_index;
    logic [TERM_W-1:0] entry_term;
    logic [IDX_W-1:0]  upper_index;
  } clb_in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [TERM_W-1:0] term_out;
    logic [IDX_W-1:0]  last_index_out;
    logic              last;
  } clb_out_t;

  // index comparisons taken at accept time against the current run
  typedef struct packed {
    logic at_end;    // index == first + count
    logic le_first;  // index <= first
    logic in_run;    // index held in the run
    logic lo_gt_hi;  // slice bounds reversed
    logic oob;       // slice reaches outside the run
  } clb_dec_t;

endpackage

### design/consensus_log_buffer_core.sv
// Channel   Direction  Payload    Transfer when
// in_       input      clb_in_t   in_valid  && !in_stall
// out_      output     clb_out_t  out_valid && !out_stall
//
// Steps: append, restore, last-index and lookup go through accept, execute and
// respond; stable_to adds a compare after its read (read, compare, update); a
// slice sends one term a cycle unless the output stalls (single term-ring read port).
// Reset clears the run (first index, count, head slot) at once; the ring itself
// is left as it is, since only slots inside the live run are ever read.
// A stalled output holds its result; the input is taken only while idle.
module consensus_log_buffer_core
  import clb_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  clb_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output clb_out_t out_data
);

  localparam int SLOT_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_CHECK = 4'b0100,
    S_RESP  = 4'b1000
  } state_t;

  // Ring slot of an offset from the head; the offset may equal DEPTH.
  function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] hd,
                                                input logic [CNT_W-1:0]  off);
    logic [CNT_W-1:0] wrapped;
    logic [SLOT_W:0]  sum;
    wrapped = (off >= CNT_W'(DEPTH)) ? off - CNT_W'(DEPTH) : off;
    sum = {1'b0, hd} + (SLOT_W+1)'(wrapped);
    if (sum >= (SLOT_W+1)'(DEPTH)) sum = sum - (SLOT_W+1)'(DEPTH);
    return sum[SLOT_W-1:0];
  endfunction

  // Run state
  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  first_r, first_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [SLOT_W-1:0] head_r, head_nxt;

  // Operation held across its cycles
  logic [FUNC_W-1:0] op_r, op_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [TERM_W-1:0] term_r, term_nxt;
  clb_dec_t          dec_r, dec_nxt;
  logic [CNT_W-1:0]  diff_r, diff_nxt;   // index - first, valid when in range
  logic [CNT_W-1:0]  rem_r, rem_nxt;     // slice terms still to send
  logic [SLOT_W-1:0] sl_slot_r, sl_slot_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic              sel_term_r, sel_term_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  clb_out_t          out_data_r, out_data_nxt;

  // Term ring: one write port, one registered read port
  logic [TERM_W-1:0] mem [DEPTH];
  logic [TERM_W-1:0] rdata_r;
  logic              mem_we, mem_re;
  logic [SLOT_W-1:0] mem_waddr, mem_raddr;
  logic [TERM_W-1:0] mem_wdata;

  logic              in_xfer, out_free;
  logic [IDX_W-1:0]  run_end, idx_diff, hi_diff, span;
  logic [IDX_W-1:0]  last_idx;
  logic [CNT_W-1:0]  k_drop;
  logic [SLOT_W-1:0] exec_slot;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Index arithmetic on the incoming item, against the run as it stands
  assign run_end  = first_r + IDX_W'(count_r);
  assign idx_diff = in_data.entry_index - first_r;
  assign hi_diff  = in_data.upper_index - first_r;
  assign span     = in_data.upper_index - in_data.entry_index;

  assign last_idx  = (count_r != '0) ? first_r + IDX_W'(count_r) - IDX_W'(1) : '0;
  assign k_drop    = diff_r + CNT_W'(1);
  assign exec_slot = slot_of(head_r, diff_r);

  always_comb begin
    state_nxt     = state_r;
    first_nxt     = first_r;
    count_nxt     = count_r;
    head_nxt      = head_r;
    op_nxt        = op_r;
    idx_nxt       = idx_r;
    term_nxt      = term_r;
    dec_nxt       = dec_r;
    diff_nxt      = diff_r;
    rem_nxt       = rem_r;
    sl_slot_nxt   = sl_slot_r;
    status_nxt    = status_r;
    sel_term_nxt  = sel_term_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = exec_slot;
    mem_wdata     = term_r;
    mem_re        = 1'b0;
    mem_raddr     = exec_slot;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          op_nxt           = in_data.func;
          idx_nxt          = in_data.entry_index;
          term_nxt         = in_data.entry_term;
          diff_nxt         = idx_diff[CNT_W-1:0];
          rem_nxt          = span[CNT_W-1:0];
          dec_nxt.at_end   = (in_data.entry_index == run_end);
          dec_nxt.le_first = (in_data.entry_index <= first_r);
          dec_nxt.in_run   = (in_data.entry_index >= first_r) &&
                             (idx_diff < IDX_W'(count_r));
          dec_nxt.lo_gt_hi = (in_data.entry_index > in_data.upper_index);
          dec_nxt.oob      = (in_data.entry_index < first_r) ||
                             (hi_diff > IDX_W'(count_r));
          state_nxt        = S_EXEC;
        end
      end

      S_EXEC: begin
        status_nxt   = ST_OK;
        sel_term_nxt = 1'b0;
        state_nxt    = S_RESP;
        case (op_r)
          FN_APPEND: begin
            if (dec_r.at_end) begin
              if (count_r == CNT_W'(DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = slot_of(head_r, count_r);
                count_nxt = count_r + CNT_W'(1);
              end
            end else if (dec_r.le_first) begin
              // rebase: the run restarts at this index in slot zero
              mem_we    = 1'b1;
              mem_waddr = '0;
              first_nxt = idx_r;
              head_nxt  = '0;
              count_nxt = CNT_W'(1);
            end else if (dec_r.in_run) begin
              // cut the conflicting tail, then overwrite its first slot
              mem_we    = 1'b1;
              count_nxt = diff_r + CNT_W'(1);
            end else begin
              status_nxt = ST_GAP;
            end
          end
          FN_STABLE_TO: begin
            if (dec_r.in_run) begin
              mem_re    = 1'b1;
              state_nxt = S_CHECK;
            end else begin
              status_nxt = ST_NOT_FOUND;
            end
          end
          FN_RESTORE: begin
            first_nxt = idx_r + IDX_W'(1);
            head_nxt  = '0;
            count_nxt = '0;
          end
          FN_LOOKUP: begin
            if (dec_r.in_run) begin
              mem_re       = 1'b1;
              sel_term_nxt = 1'b1;
            end else begin
              status_nxt = ST_NOT_FOUND;
            end
          end
          FN_LAST_IDX: begin
            if (count_r == '0) status_nxt = ST_NOT_FOUND;
          end
          FN_SLICE: begin
            if (dec_r.lo_gt_hi) begin
              status_nxt = ST_BAD_RANGE;
            end else if (dec_r.oob) begin
              status_nxt = ST_OUT_OF_BOUND;
            end else if (rem_r == '0) begin
              // empty slice: nothing to send
              state_nxt = S_IDLE;
            end else begin
              mem_re       = 1'b1;
              sl_slot_nxt  = exec_slot;
              sel_term_nxt = 1'b1;
            end
          end
          default: begin
            status_nxt = ST_BAD_RANGE;
          end
        endcase
      end

      S_CHECK: begin
        state_nxt = S_RESP;
        if (rdata_r == term_r) begin
          // drop the prefix up to and including the matched index
          head_nxt  = slot_of(head_r, k_drop);
          count_nxt = count_r - k_drop;
          first_nxt = idx_r + IDX_W'(1);
        end else begin
          status_nxt = ST_NOT_FOUND;
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.status         = status_r;
          out_data_nxt.term_out       = (sel_term_r && status_r == ST_OK) ? rdata_r : '0;
          out_data_nxt.last_index_out = last_idx;
          out_data_nxt.last           = 1'b1;
          if (op_r == FN_SLICE && status_r == ST_OK) begin
            out_data_nxt.last = (rem_r == CNT_W'(1));
            if (rem_r == CNT_W'(1)) begin
              state_nxt = S_IDLE;
            end else begin
              // advance to the next slot and fetch its term
              rem_nxt     = rem_r - CNT_W'(1);
              sl_slot_nxt = (sl_slot_r == SLOT_W'(DEPTH - 1)) ? '0
                                                               : sl_slot_r + SLOT_W'(1);
              mem_re      = 1'b1;
              mem_raddr   = sl_slot_nxt;
            end
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      first_r     <= '0;
      count_r     <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      first_r     <= first_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    idx_r      <= idx_nxt;
    term_r     <= term_nxt;
    dec_r      <= dec_nxt;
    diff_r     <= diff_nxt;
    rem_r      <= rem_nxt;
    sl_slot_r  <= sl_slot_nxt;
    status_r   <= status_nxt;
    sel_term_r <= sel_term_nxt;
    out_data_r <= out_data_nxt;
  end

  // Term ring. Accesses of one item are cycles apart, so a read never meets
  // a write to the same slot in flight.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_re) rdata_r <= mem[mem_raddr];
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count beyond ring depth");

  a_single_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("ring read and write in one cycle");

  a_load_in_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_RESP)
    else $error("result loaded outside response state");

  a_slice_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && op_r == FN_SLICE && status_r == ST_OK) |-> rem_r != '0)
    else $error("slice streaming with nothing left");

  a_state_change_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |-> $past(state_r) == S_IDLE)
    else $error("operation started without an input transfer");

endmodule

### test/consensus_log_buffer_core_test.sv
`timescale 1ns / 1ps

module consensus_log_buffer_core_test;
  import clb_pkg::*;

  localparam int RING_DEPTH = 64;
  localparam int HOLD_CYCLES = 200;
  localparam int TAIL_CYCLES = 40;
  localparam int CYCLE_LIMIT = 300000;
  localparam logic [IDX_W-1:0] ALL_ONES = '1;
  // func codes that the block does not know; both must answer bad_range
  localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  clb_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  clb_out_t out_data;

  consensus_log_buffer_core #(.DEPTH(RING_DEPTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Shadow of the log: ring of terms plus the live run (first index, count, head slot).
  logic [TERM_W-1:0] term_ring [RING_DEPTH];
  logic [IDX_W-1:0]  run_first = '0;
  int                run_count = 0;
  logic [5:0]        run_head = '0;

  clb_out_t expected_replies[$];
  int failures = 0;
  int ops_sent = 0;
  int replies_seen = 0;
  int cycle_count = 0;

  // Receiver idling: random bursts, plus one long hold-off on request.
  logic idle_on = 1'b0;
  int   hold_req = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   stall_left = 0;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic clb_in_t make_op(logic [FUNC_W-1:0] fn, logic [IDX_W-1:0] idx,
                                      logic [TERM_W-1:0] term, logic [IDX_W-1:0] hi);
    return '{func: fn, entry_index: idx, entry_term: term, upper_index: hi};
  endfunction

  // Ring slot of the entry at a given offset from the first index.
  function automatic logic [5:0] slot_of(logic [IDX_W-1:0] off);
    return run_head + off[5:0];
  endfunction

  function automatic logic holds(logic [IDX_W-1:0] idx);
    return idx >= run_first && (idx - run_first) < 64'(run_count);
  endfunction

  function automatic logic [IDX_W-1:0] last_index_now();
    return (run_count != 0) ? run_first + 64'(run_count) - 64'd1 : '0;
  endfunction

  // Work out the replies of one accepted operation and advance the shadow log.
  task automatic apply_log_op(input clb_in_t op);
    logic [IDX_W-1:0]  run_end;
    logic [IDX_W-1:0]  rel;
    logic [IDX_W-1:0]  span;
    logic [STAT_W-1:0] st;
    logic [TERM_W-1:0] found;
    logic              do_write;
    run_end = run_first + 64'(run_count);
    rel = op.entry_index - run_first;
    st = ST_OK;
    found = '0;
    do_write = 1'b0;
    case (op.func)
      FN_APPEND: begin
        if (op.entry_index == run_end) begin
          if (run_count >= RING_DEPTH) st = ST_FULL;
          else do_write = 1'b1;
        end else if (op.entry_index <= run_first) begin
          // rebase: clear the run and start again at this index
          run_count = 0;
          run_head = '0;
          run_first = op.entry_index;
          do_write = 1'b1;
        end else if (rel < 64'(run_count)) begin
          // conflict: cut the tail back to this index
          run_count = int'(rel);
          do_write = 1'b1;
        end else begin
          st = ST_GAP;
        end
        if (do_write) begin
          term_ring[slot_of(64'(run_count))] = op.entry_term;
          run_count++;
        end
      end
      FN_STABLE_TO: begin
        if (holds(op.entry_index) && term_ring[slot_of(rel)] == op.entry_term) begin
          run_head = slot_of(rel + 64'd1);
          run_count -= int'(rel) + 1;
          run_first = op.entry_index + 64'd1;
        end else begin
          st = ST_NOT_FOUND;
        end
      end
      FN_RESTORE: begin
        run_count = 0;
        run_head = '0;
        run_first = op.entry_index + 64'd1;
      end
      FN_LOOKUP: begin
        if (holds(op.entry_index)) found = term_ring[slot_of(rel)];
        else st = ST_NOT_FOUND;
      end
      FN_LAST_IDX: begin
        if (run_count == 0) st = ST_NOT_FOUND;
      end
      FN_SLICE: begin
        if (op.entry_index > op.upper_index) begin
          st = ST_BAD_RANGE;
        end else if (op.entry_index < run_first ||
                     op.upper_index - run_first > 64'(run_count)) begin
          st = ST_OUT_OF_BOUND;
        end else begin
          // one reply per term; an empty slice gives none
          span = op.upper_index - op.entry_index;
          for (int i = 0; i < int'(span); i++)
            expected_replies.push_back('{status: ST_OK,
                                         term_out: term_ring[slot_of(rel + 64'(i))],
                                         last_index_out: last_index_now(),
                                         last: (i + 1 == int'(span))});
          return;
        end
      end
      default: st = ST_BAD_RANGE;
    endcase
    expected_replies.push_back('{status: st, term_out: found,
                                 last_index_out: last_index_now(), last: 1'b1});
  endtask

  // Offer one operation and hold it until the block takes the transfer.
  task automatic issue_op(input clb_in_t op);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= op;
    do @(posedge clk); while (in_stall);
    apply_log_op(op);
    ops_sent++;
  endtask

  // Drop valid and wait until every awaited reply has come back.
  task automatic await_all_replies();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_replies.size() != 0);
  endtask

  // Mostly well-formed operations aimed at the live run, with some noise.
  function automatic clb_in_t draw_log_op();
    clb_in_t          op;
    logic [IDX_W-1:0] run_end;
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    int               sel;
    run_end = run_first + 64'(run_count);
    op = make_op(FN_APPEND, run_end, rand64(), rand64());
    if ($urandom_range(0, 3) == 0) op.entry_term = 64'($urandom_range(0, 7));
    sel = $urandom_range(0, 99);
    if (sel < 36) begin
      case ($urandom_range(0, 9))
        0: if (run_count != 0)
             op.entry_index = run_first + 64'($urandom_range(0, run_count - 1));
        1: op.entry_index = run_first - 64'($urandom_range(0, 3));
        2: op.entry_index = run_end + 64'($urandom_range(1, 4));
        default: ;
      endcase
    end else if (sel < 46) begin
      op.func = FN_STABLE_TO;
      if (run_count != 0 && $urandom_range(0, 9) < 7) begin
        a = 64'($urandom_range(0, run_count - 1));
        op.entry_index = run_first + a;
        op.entry_term = term_ring[slot_of(a)];
      end else begin
        op.entry_index = run_first + 64'($urandom_range(0, run_count + 1));
      end
    end else if (sel < 49) begin
      op.func = FN_RESTORE;
      op.entry_index = $urandom_range(0, 1) ? rand64() : run_end + 64'($urandom_range(0, 5));
    end else if (sel < 63) begin
      op.func = FN_LOOKUP;
      op.entry_index = run_first + 64'($urandom_range(0, run_count + 1)) - 64'd1;
    end else if (sel < 71) begin
      op.func = FN_LAST_IDX;
    end else if (sel < 86) begin
      op.func = FN_SLICE;
      a = 64'($urandom_range(0, run_count));
      b = 64'($urandom_range(int'(a), run_count));
      op.entry_index = run_first + a;
      op.upper_index = run_first + b;
      case ($urandom_range(0, 6))
        0: begin
          op.entry_index = run_first + b + 64'd1;
          op.upper_index = run_first + a;
        end
        1: op.upper_index = run_end + 64'($urandom_range(1, 3));
        2: op.entry_index = run_first - 64'd1;
        default: ;
      endcase
    end else if (sel < 89) begin
      op.func = $urandom_range(0, 1) ? FN_SPARE_6 : FN_SPARE_7;
    end else begin
      op = make_op(FUNC_W'($urandom_range(0, 7)), rand64(), rand64(), rand64());
    end
    return op;
  endfunction

  // Receiver side: long hold-off when asked, otherwise short random stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic report_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      failures++;
    end
  endtask

  // Check every reply transfer against the oldest awaited one.
  always @(posedge clk) begin : check_replies
    clb_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      replies_seen++;
      if (expected_replies.size() == 0) begin
        $display("%0t: reply with nothing awaited: expected none, actual %h",
                 $time, out_data);
        failures++;
      end else begin
        want = expected_replies.pop_front();
        report_field("status", 64'(want.status), 64'(out_data.status));
        report_field("term_out", want.term_out, out_data.term_out);
        report_field("last_index_out", want.last_index_out, out_data.last_index_out);
        report_field("last", 64'(want.last), 64'(out_data.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("consensus_log_buffer_core test failed");
      $finish;
    end
  end

  // Extremes, every func code and each named corner of the log.
  task automatic test_directed();
    issue_op(make_op(FN_LAST_IDX, '0, '0, '0));           // empty store
    issue_op(make_op(FN_LOOKUP, '0, '0, '0));             // lookup on empty store
    issue_op(make_op(FN_SLICE, '0, '0, '0));              // empty slice, no reply
    issue_op(make_op(FN_APPEND, 64'd0, ALL_ONES, '0));
    issue_op(make_op(FN_APPEND, 64'd1, '0, ALL_ONES));
    issue_op(make_op(FN_APPEND, 64'd3, 64'd4, '0));       // index gap
    issue_op(make_op(FN_APPEND, 64'd2, 64'd5, '0));
    issue_op(make_op(FN_LOOKUP, 64'd1, '0, '0));
    issue_op(make_op(FN_SLICE, 64'd0, '0, 64'd3));
    issue_op(make_op(FN_SLICE, 64'd2, '0, 64'd1));        // reversed bounds
    issue_op(make_op(FN_SLICE, 64'd0, '0, ALL_ONES));     // past the run
    issue_op(make_op(FN_APPEND, 64'd1, 64'd7, '0));       // conflicting tail
    issue_op(make_op(FN_STABLE_TO, 64'd0, 64'd3, '0));    // term differs
    issue_op(make_op(FN_STABLE_TO, 64'd0, ALL_ONES, '0));
    issue_op(make_op(FN_LOOKUP, 64'd0, '0, '0));          // now below the run
    issue_op(make_op(FN_APPEND, 64'd0, 64'd9, '0));       // rebase at or below first
    issue_op(make_op(FN_RESTORE, ALL_ONES, '0, '0));      // index + 1 wraps to zero
    issue_op(make_op(FN_RESTORE, ALL_ONES - 64'd2, '0, '0));
    issue_op(make_op(FN_APPEND, ALL_ONES - 64'd1, 64'd1, '0));
    issue_op(make_op(FN_APPEND, ALL_ONES, 64'd2, '0));
    issue_op(make_op(FN_APPEND, 64'd0, 64'd3, '0));       // end of run wraps
    issue_op(make_op(FN_LAST_IDX, '0, '0, '0));
    issue_op(make_op(FN_SPARE_6, ALL_ONES, ALL_ONES, ALL_ONES));
    issue_op(make_op(FN_SPARE_7, '0, '0, '0));
    issue_op(make_op(FN_RESTORE, '0, '0, '0));
  endtask

  // Fill the ring, overflow it, move the head and wrap the slots round.
  task automatic test_full_store();
    issue_op(make_op(FN_RESTORE, rand64() >> 1, rand64(), rand64()));
    repeat (RING_DEPTH)
      issue_op(make_op(FN_APPEND, run_first + 64'(run_count), rand64(), rand64()));
    issue_op(make_op(FN_APPEND, run_first + 64'(run_count), rand64(), rand64()));
    issue_op(make_op(FN_SLICE, run_first, '0, run_first + 64'(run_count)));
    issue_op(make_op(FN_STABLE_TO, run_first + 64'd20, term_ring[slot_of(64'd20)], '0));
    repeat (21)
      issue_op(make_op(FN_APPEND, run_first + 64'(run_count), rand64(), rand64()));
    issue_op(make_op(FN_APPEND, run_first + 64'(run_count), rand64(), rand64()));
    issue_op(make_op(FN_SLICE, run_first, '0, run_first + 64'(run_count)));
    repeat (3)
      issue_op(make_op(FN_LOOKUP, run_first + 64'($urandom_range(0, RING_DEPTH - 1)),
                       '0, '0));
    issue_op(make_op(FN_STABLE_TO, run_first + 64'd63, term_ring[slot_of(64'd63)], '0));
    issue_op(make_op(FN_LAST_IDX, '0, '0, '0));
  endtask

  // Hold the receiver off while operations keep coming, so the input backs up.
  task automatic test_backpressure();
    hold_req <= hold_req + 1;
    repeat (12) issue_op(draw_log_op());
    await_all_replies();
  endtask

  // Pause the sender until the block has emptied, then carry on.
  task automatic test_drain_pause();
    repeat (6) issue_op(draw_log_op());
    await_all_replies();
    repeat (6) issue_op(draw_log_op());
  endtask

  task automatic test_random_ops(input int n);
    repeat (n) issue_op(draw_log_op());
  endtask

  initial begin
    for (int i = 0; i < RING_DEPTH; i++) term_ring[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    idle_on <= 1'b1;
    @(posedge clk);

    test_directed();
    test_full_store();
    test_backpressure();
    test_drain_pause();
    test_random_ops(20);
    // closing stretch runs with no idling on either side
    idle_on <= 1'b0;
    test_random_ops(15);

    await_all_replies();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d operations and %0d replies: extremes, full ring, gaps,",
             ops_sent, replies_seen);
    $display("conflicts, rebases, index wrap, slices, back-pressure and drains.");
    if (failures == 0) begin
      $display("consensus_log_buffer_core test passed");
    end else begin
      $display("consensus_log_buffer_core test failed");
    end
    $finish;
  end

endmodule
